// ----- rtl/tsf_pkg.sv -----
package tsf_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register widths and reset values
    localparam int DIM_W      = 13;
    localparam int COLOUR_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int XOUT_W     = 12;

    localparam logic [DIM_W-1:0]    MAX_DIM          = DIM_W'(4096);
    localparam logic [DIM_W-1:0]    WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0]    HEIGHT_RESET     = DIM_W'(480);
    localparam logic [COLOUR_W-1:0] COLOUR_RESET     = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_FILL_COLOUR  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LOWER = 2'd1,
        PH_UPPER = 2'd2
    } phase_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SWAP01,
        OP_SWAP12,
        OP_MAC0,
        OP_MAC1,
        OP_DIV_SPLIT,
        OP_WB_SPLIT,
        OP_DIV_L0,
        OP_DIV_L1,
        OP_DIV_U0,
        OP_DIV_U1,
        OP_WB_S0,
        OP_WB_L1,
        OP_WB_U1,
        OP_SPAN
    } op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DISPATCH,
        JC_UPPER_ONLY,
        JC_TO_UPPER
    } cond_t;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] ADDR_IDLE  = PC_W'(0);
    localparam logic [PC_W-1:0] ADDR_SORT  = PC_W'(1);
    localparam logic [PC_W-1:0] ADDR_UPPER = PC_W'(12);
    localparam logic [PC_W-1:0] ADDR_SPAN  = PC_W'(16);

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            ret;
        logic            wait_div;
        logic            wait_out;
    } ucode_t;

    typedef struct packed {
        logic upper_only;
        logic to_upper;
        logic div_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [XOUT_W-1:0] start_x;
        logic [XOUT_W-1:0] end_x;
        logic              empty;
        logic              last;
    } span_t;

endpackage

// ----- rtl/tsf_div.sv -----
module tsf_div
    import tsf_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 13
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    busy,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   rem_sh;

    assign busy = (cnt_reg != '0);
    assign quot = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        rem_sh   = {rem_reg, mag_reg[NUM_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            neg_next = num[NUM_W-1];
            mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_next = '0;
            den_next = den;
        end
        else if (busy)
        begin
            // one restoring step per cycle, quotient bits shift in from the right
            cnt_next = cnt_reg - CNT_W'(1);
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                mag_next = {mag_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                mag_next = {mag_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

endmodule

// ----- rtl/tsf_seq.sv -----
module tsf_seq
    import tsf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_command,
    input  dp_stat_t        stat,
    input  logic            out_full,
    output op_t             op,
    output logic            in_ready,
    output logic [PC_W-1:0] pc
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] step;
    logic [PC_W-1:0] fall;
    ucode_t          uw;
    logic            stall;

    function automatic ucode_t uword(op_t o, cond_t c, logic [PC_W-1:0] t,
                                     logic r, logic wd, logic wo);
        ucode_t u;
        u.op       = o;
        u.cond     = c;
        u.target   = t;
        u.ret      = r;
        u.wait_div = wd;
        u.wait_out = wo;
        return u;
    endfunction

    // microprogram: start items run sort, split and slope set-up, step items
    // run the single span word and, at the lower-to-upper hand-over, the upper slope set-up
    function automatic ucode_t rom(logic [PC_W-1:0] a);
        ucode_t u;
        unique case (a)
            ADDR_IDLE:   u = uword(OP_LOAD,      JC_DISPATCH,   ADDR_SPAN,  1'b0, 1'b0, 1'b0);
            PC_W'(1):    u = uword(OP_SWAP01,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(2):    u = uword(OP_SWAP12,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(3):    u = uword(OP_SWAP01,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(4):    u = uword(OP_MAC0,      JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(5):    u = uword(OP_MAC1,      JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(6):    u = uword(OP_DIV_SPLIT, JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(7):    u = uword(OP_WB_SPLIT,  JC_UPPER_ONLY, ADDR_UPPER, 1'b0, 1'b1, 1'b0);
            PC_W'(8):    u = uword(OP_DIV_L0,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(9):    u = uword(OP_WB_S0,     JC_NEXT,       ADDR_IDLE,  1'b0, 1'b1, 1'b0);
            PC_W'(10):   u = uword(OP_DIV_L1,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(11):   u = uword(OP_WB_L1,     JC_ALWAYS,     ADDR_IDLE,  1'b0, 1'b1, 1'b0);
            ADDR_UPPER:  u = uword(OP_DIV_U0,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(13):   u = uword(OP_WB_S0,     JC_NEXT,       ADDR_IDLE,  1'b0, 1'b1, 1'b0);
            PC_W'(14):   u = uword(OP_DIV_U1,    JC_NEXT,       ADDR_IDLE,  1'b0, 1'b0, 1'b0);
            PC_W'(15):   u = uword(OP_WB_U1,     JC_ALWAYS,     ADDR_IDLE,  1'b0, 1'b1, 1'b0);
            ADDR_SPAN:   u = uword(OP_SPAN,      JC_TO_UPPER,   ADDR_UPPER, 1'b1, 1'b0, 1'b1);
            default:     u = uword(OP_NOP,       JC_ALWAYS,     ADDR_IDLE,  1'b0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

    assign pc = pc_reg;

    always_comb
    begin
        uw       = rom(pc_reg);
        stall    = (uw.wait_div && stat.div_busy) || (uw.wait_out && out_full);
        in_ready = (uw.cond == JC_DISPATCH);
        step     = pc_reg + PC_W'(1);
        fall     = uw.ret ? ADDR_IDLE : step;
        op       = OP_NOP;
        pc_next  = pc_reg;
        if (!stall)
        begin
            op = uw.op;
            unique case (uw.cond)
                JC_NEXT:
                begin
                    pc_next = step;
                end
                JC_ALWAYS:
                begin
                    pc_next = uw.target;
                end
                JC_DISPATCH:
                begin
                    // vertices are loaded only on a start transfer
                    if (!in_valid)
                    begin
                        op = OP_NOP;
                    end
                    else if (in_command)
                    begin
                        op      = OP_NOP;
                        pc_next = uw.target;
                    end
                    else
                    begin
                        pc_next = step;
                    end
                end
                JC_UPPER_ONLY:
                begin
                    pc_next = stat.upper_only ? uw.target : fall;
                end
                JC_TO_UPPER:
                begin
                    pc_next = stat.to_upper ? uw.target : fall;
                end
                default:
                begin
                    pc_next = ADDR_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ADDR_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/tsf_dp.sv -----
module tsf_dp
    import tsf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  op_t                          op,
    input  logic [6*COORD_BITS-1:0]      vert_in,
    input  logic [DIM_W-1:0]             image_width,
    input  logic [DIM_W-1:0]             image_height,
    output dp_stat_t                     stat,
    output logic                         span_emit,
    output logic signed [COORD_BITS-1:0] span_row,
    output span_t                        span
);

    localparam int CW1   = COORD_BITS + 1;
    localparam int POS_W = COORD_BITS + FRAC_BITS + 3;
    localparam int XA_W  = POS_W - FRAC_BITS;
    localparam int DIV_W = (2 * COORD_BITS + 3 > POS_W) ? 2 * COORD_BITS + 3 : POS_W;
    localparam int PRD_W = 2 * CW1;
    localparam int CMP_W = (XA_W > DIM_W + 2) ? XA_W : DIM_W + 2;

    logic signed [COORD_BITS-1:0] vx_reg [3];
    logic signed [COORD_BITS-1:0] vx_next [3];
    logic signed [COORD_BITS-1:0] vy_reg [3];
    logic signed [COORD_BITS-1:0] vy_next [3];
    logic signed [COORD_BITS-1:0] split_reg, split_next;
    logic signed [POS_W-1:0]      slope_reg [2];
    logic signed [POS_W-1:0]      slope_next [2];
    logic signed [POS_W-1:0]      pos_reg [2];
    logic signed [POS_W-1:0]      pos_next [2];
    logic signed [COORD_BITS-1:0] row_reg, row_next;
    phase_t                       phase_reg, phase_next;
    logic signed [DIV_W-1:0]      acc_reg, acc_next;
    logic                         dz_reg, dz_next;

    logic signed [CW1-1:0]        dx10, dx20, dx21, dxs0, dx2s;
    logic signed [CW1-1:0]        d10, d20, d21;
    logic signed [CW1-1:0]        ma, mb;
    logic signed [PRD_W-1:0]      prod;

    logic                         div_start;
    logic signed [DIV_W-1:0]      div_num;
    logic [COORD_BITS-1:0]        div_den;
    logic                         div_busy;
    logic signed [DIV_W-1:0]      div_quot;
    logic signed [POS_W-1:0]      slope_q;

    logic signed [XA_W-1:0]       xa, xb;
    logic signed [CMP_W-1:0]      xa_c, xb_c, lo, hi, lo_cl, hi_cl;
    logic signed [CMP_W-1:0]      row_c, w_c, h_c;
    logic [DIM_W-1:0]             w_eff;
    logic                         empty;
    logic                         active;
    logic                         lower_end, upper_exists, upper_end;

    tsf_div #(
        .NUM_W (DIV_W),
        .DEN_W (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_comb
    begin
        dx10 = CW1'(vx_reg[1]) - CW1'(vx_reg[0]);
        dx20 = CW1'(vx_reg[2]) - CW1'(vx_reg[0]);
        dx21 = CW1'(vx_reg[2]) - CW1'(vx_reg[1]);
        dxs0 = CW1'(split_reg) - CW1'(vx_reg[0]);
        dx2s = CW1'(vx_reg[2]) - CW1'(split_reg);
        d10  = CW1'(vy_reg[1]) - CW1'(vy_reg[0]);
        d20  = CW1'(vy_reg[2]) - CW1'(vy_reg[0]);
        d21  = CW1'(vy_reg[2]) - CW1'(vy_reg[1]);
    end

    // one shared multiplier for the split point numerator
    always_comb
    begin
        ma   = (op == OP_MAC0) ? CW1'(vx_reg[0]) : d10;
        mb   = (op == OP_MAC0) ? d20 : dx20;
        prod = PRD_W'(ma) * PRD_W'(mb);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (op)
            OP_DIV_SPLIT:
            begin
                div_start = 1'b1;
                div_num   = acc_reg;
                div_den   = d20[COORD_BITS-1:0];
            end
            OP_DIV_L0:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(dx10) <<< FRAC_BITS;
                div_den   = d10[COORD_BITS-1:0];
            end
            OP_DIV_L1:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(dxs0) <<< FRAC_BITS;
                div_den   = d10[COORD_BITS-1:0];
            end
            OP_DIV_U0:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(dx21) <<< FRAC_BITS;
                div_den   = d21[COORD_BITS-1:0];
            end
            OP_DIV_U1:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(dx2s) <<< FRAC_BITS;
                div_den   = d21[COORD_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // span geometry: edge positions truncated toward zero, then clipped
    always_comb
    begin
        xa = pos_reg[0][POS_W-1:FRAC_BITS]
           + XA_W'(pos_reg[0][POS_W-1] && (pos_reg[0][FRAC_BITS-1:0] != '0));
        xb = pos_reg[1][POS_W-1:FRAC_BITS]
           + XA_W'(pos_reg[1][POS_W-1] && (pos_reg[1][FRAC_BITS-1:0] != '0));
        xa_c  = CMP_W'(xa);
        xb_c  = CMP_W'(xb);
        lo    = (xa_c < xb_c) ? xa_c : xb_c;
        hi    = (xa_c < xb_c) ? xb_c : xa_c;
        w_eff = (image_width > MAX_DIM) ? MAX_DIM : image_width;
        w_c   = CMP_W'(signed'({1'b0, w_eff}));
        h_c   = CMP_W'(signed'({1'b0, image_height}));
        row_c = CMP_W'(row_reg);
        empty = (row_c < 0) || (row_c >= h_c) || (hi < 0) || (lo >= w_c);
        lo_cl = (lo < 0) ? '0 : lo;
        hi_cl = (hi > w_c - CMP_W'(1)) ? w_c - CMP_W'(1) : hi;

        active       = (phase_reg == PH_LOWER) || (phase_reg == PH_UPPER);
        lower_end    = (row_reg >= vy_reg[1]);
        upper_exists = (vy_reg[2] > vy_reg[1]);
        upper_end    = (CW1'(row_reg) <= CW1'(vy_reg[1]) + CW1'(1));

        span_emit     = (op == OP_SPAN) && active;
        span_row      = row_reg;
        span.empty    = empty;
        span.start_x  = empty ? '0 : lo_cl[XOUT_W-1:0];
        span.end_x    = empty ? '0 : hi_cl[XOUT_W-1:0];
        span.last     = (phase_reg == PH_LOWER) ? (lower_end && !upper_exists) : upper_end;

        stat.upper_only = (vy_reg[0] == vy_reg[1]) && upper_exists;
        stat.to_upper   = (phase_reg == PH_LOWER) && lower_end && upper_exists;
        stat.div_busy   = div_busy;
    end

    always_comb
    begin
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        split_next = split_reg;
        slope_next = slope_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dz_next    = div_start ? (div_den == '0) : dz_reg;
        slope_q    = dz_reg ? '0 : div_quot[POS_W-1:0];
        unique case (op)
            OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vx_next[i] = vert_in[2*i*COORD_BITS +: COORD_BITS];
                    vy_next[i] = vert_in[(2*i+1)*COORD_BITS +: COORD_BITS];
                end
                phase_next = PH_IDLE;
            end
            OP_SWAP01:
            begin
                if (vy_reg[1] < vy_reg[0])
                begin
                    vx_next[0] = vx_reg[1];
                    vy_next[0] = vy_reg[1];
                    vx_next[1] = vx_reg[0];
                    vy_next[1] = vy_reg[0];
                end
            end
            OP_SWAP12:
            begin
                if (vy_reg[2] < vy_reg[1])
                begin
                    vx_next[1] = vx_reg[2];
                    vy_next[1] = vy_reg[2];
                    vx_next[2] = vx_reg[1];
                    vy_next[2] = vy_reg[1];
                end
            end
            OP_MAC0:
            begin
                acc_next = DIV_W'(prod);
            end
            OP_MAC1:
            begin
                acc_next = acc_reg + DIV_W'(prod);
            end
            OP_WB_SPLIT:
            begin
                // all three rows equal: split sits on the last vertex
                split_next = dz_reg ? vx_reg[2] : div_quot[COORD_BITS-1:0];
            end
            OP_WB_S0:
            begin
                slope_next[0] = slope_q;
            end
            OP_WB_L1:
            begin
                slope_next[1] = slope_q;
                pos_next[0]   = POS_W'(vx_reg[0]) <<< FRAC_BITS;
                pos_next[1]   = POS_W'(vx_reg[0]) <<< FRAC_BITS;
                row_next      = vy_reg[0];
                phase_next    = PH_LOWER;
            end
            OP_WB_U1:
            begin
                slope_next[1] = slope_q;
                pos_next[0]   = POS_W'(vx_reg[2]) <<< FRAC_BITS;
                pos_next[1]   = POS_W'(vx_reg[2]) <<< FRAC_BITS;
                row_next      = vy_reg[2];
                phase_next    = PH_UPPER;
            end
            OP_SPAN:
            begin
                if (phase_reg == PH_LOWER)
                begin
                    pos_next[0] = pos_reg[0] + slope_reg[0];
                    pos_next[1] = pos_reg[1] + slope_reg[1];
                    row_next    = row_reg + COORD_BITS'(1);
                    if (lower_end && !upper_exists)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else if (phase_reg == PH_UPPER)
                begin
                    pos_next[0] = pos_reg[0] - slope_reg[0];
                    pos_next[1] = pos_reg[1] - slope_reg[1];
                    row_next    = row_reg - COORD_BITS'(1);
                    if (upper_end)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        split_reg <= split_next;
        slope_reg <= slope_next;
        pos_reg   <= pos_next;
        row_reg   <= row_next;
        acc_reg   <= acc_next;
        dz_reg    <= dz_next;
    end

endmodule

// ----- rtl/triangle_scanline_fill.sv -----
// channel   direction  handshake          payload
// s_axis    in         s_tvalid/s_tready  s_tdata vertices, s_tuser command
// m_axis    out        m_tvalid/m_tready  m_tdata span, m_tuser empty, m_tlast last
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// a step item runs the dispatch word then the span word (longer if m side stalls)
// a start item runs three radix-2 divisions of DIV_W bits, DIV_W = max(2*COORD_BITS+3,
// COORD_BITS+FRAC_BITS+3); the lower-to-upper hand-over inside a triangle adds two divisions
// reset clears sequencer, phase, divider count and output valid, and loads the config reset values
// the output register lets a new item in while a span waits on m_tready
module triangle_scanline_fill
    import tsf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // span_row, span_start_x, span_end_x, span_colour
    output logic [((COORD_BITS+2*XOUT_W+COLOUR_W+7)/8)*8-1:0] m_tdata,
    // span_empty
    output logic [0:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OUT_W = ((COORD_BITS + 2 * XOUT_W + COLOUR_W + 7) / 8) * 8;

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [COLOUR_W-1:0] colour_reg;

    op_t                          op;
    dp_stat_t                     stat;
    logic [PC_W-1:0]              pc;
    logic                         span_emit;
    logic signed [COORD_BITS-1:0] span_row;
    span_t                        span;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_empty_reg;
    logic             out_last_reg;

    assign cfg_ready = 1'b1;

    tsf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser[0]),
        .stat       (stat),
        .out_full   (out_valid_reg),
        .op         (op),
        .in_ready   (s_tready),
        .pc         (pc)
    );

    tsf_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .vert_in      (s_tdata[6*COORD_BITS-1:0]),
        .image_width  (width_reg),
        .image_height (height_reg),
        .stat         (stat),
        .span_emit    (span_emit),
        .span_row     (span_row),
        .span         (span)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            colour_reg <= COLOUR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_FILL_COLOUR:  colour_reg <= cfg_data[COLOUR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // the span word waits on a full output register, so a load never overwrites
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (span_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_emit)
        begin
            out_data_reg  <= OUT_W'({colour_reg, span.end_x, span.start_x, span_row});
            out_empty_reg <= span.empty;
            out_last_reg  <= span.last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_empty_reg;
    assign m_tlast    = out_last_reg;

    a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> !s_tready)
        else $error("input taken while a division is running");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        span_emit |-> !out_valid_reg)
        else $error("span loaded over a waiting result");

    a_start_enters_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |=> (pc == ADDR_SORT))
        else $error("start transfer did not enter the sort steps");

endmodule

// ----- verif/tb_top.sv -----
module tb_top
    import tsf_pkg::*;
();

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint FRAC_ONE = longint'(1) << FRAC;
    localparam int S_W = ((6*COORD_W+7)/8)*8;
    localparam int M_W = ((COORD_W+2*XOUT_W+COLOUR_W+7)/8)*8;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    // covers a start (three divisions) plus the lower-to-upper hand-over
    localparam int SETTLE_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    } tri_t;

    typedef struct {
        logic [COORD_W-1:0]  row;
        logic [XOUT_W-1:0]   start_x;
        logic [XOUT_W-1:0]   end_x;
        logic                empty;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } span_exp_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_W-1:0]        m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    triangle_scanline_fill u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // raster state as the block should hold it
    longint              clip_w = 640;
    longint              clip_h = 480;
    logic [COLOUR_W-1:0] colour_reg = '0;
    longint              vx[3];
    longint              vy[3];
    longint              split_x;
    longint              slope_l, slope_r;
    longint              pos_l, pos_r;
    longint              row_now;
    phase_t              phase = PH_IDLE;

    span_exp_t expected_spans[$];
    int        errors = 0;
    int        busy_items = 0;
    int        burst_left = 0;
    int        gap_max = 4;
    int        quiet_cycles = 0;
    rx_mode_t  rx_mode = RX_OPEN;
    int        rx_left = 0;

    function automatic longint fx_slope(input longint dx, input longint dy);
        if (dy == 0)
            return 0;
        return (dx * FRAC_ONE) / dy;
    endfunction

    function automatic longint to_pixel(input longint p);
        if (p >= 0)
            return p >>> FRAC;
        return -((-p) >>> FRAC);
    endfunction

    function automatic void enter_upper();
        longint dy;
        dy = vy[2] - vy[1];
        slope_l = fx_slope(vx[2] - vx[1], dy);
        slope_r = fx_slope(vx[2] - split_x, dy);
        pos_l = vx[2] * FRAC_ONE;
        pos_r = pos_l;
        row_now = vy[2];
        phase = PH_UPPER;
    endfunction

    function automatic void load_triangle(input tri_t t);
        longint px[3], py[3], tmp, den, dy;
        int j;
        px = '{t.ax, t.bx, t.cx};
        py = '{t.ay, t.by, t.cy};
        // insertion sort on y, ties keep input order
        for (int i = 1; i < 3; i++)
        begin
            for (j = i; j > 0 && py[j] < py[j-1]; j--)
            begin
                tmp = px[j]; px[j] = px[j-1]; px[j-1] = tmp;
                tmp = py[j]; py[j] = py[j-1]; py[j-1] = tmp;
            end
        end
        vx = px;
        vy = py;
        if (py[0] == py[2])
            split_x = px[2];
        else
        begin
            den = py[2] - py[0];
            split_x = (px[0] * den + (py[1] - py[0]) * (px[2] - px[0])) / den;
        end
        if (py[0] == py[1] && py[1] < py[2])
            enter_upper();
        else
        begin
            dy = py[1] - py[0];
            slope_l = fx_slope(px[1] - px[0], dy);
            slope_r = fx_slope(split_x - px[0], dy);
            pos_l = px[0] * FRAC_ONE;
            pos_r = pos_l;
            row_now = py[0];
            phase = PH_LOWER;
        end
    endfunction

    function automatic bit raster_step(output span_exp_t s);
        longint r, xa, xb, lo, hi, w;
        bit fin, off;
        if (phase != PH_LOWER && phase != PH_UPPER)
            return 0;
        r = row_now;
        xa = to_pixel(pos_l);
        xb = to_pixel(pos_r);
        fin = 0;
        if (phase == PH_LOWER)
        begin
            pos_l += slope_l;
            pos_r += slope_r;
            row_now = r + 1;
            if (r >= vy[1])
            begin
                if (vy[2] > vy[1])
                    enter_upper();
                else
                begin
                    phase = PH_IDLE;
                    fin = 1;
                end
            end
        end
        else
        begin
            pos_l -= slope_l;
            pos_r -= slope_r;
            row_now = r - 1;
            if (r <= vy[1] + 1)
            begin
                phase = PH_IDLE;
                fin = 1;
            end
        end
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        w = (clip_w > 4096) ? 4096 : clip_w;
        off = r < 0 || r >= clip_h || hi < 0 || lo >= w;
        if (lo < 0)
            lo = 0;
        if (hi > w - 1)
            hi = w - 1;
        s.row = r[COORD_W-1:0];
        s.start_x = off ? '0 : lo[XOUT_W-1:0];
        s.end_x = off ? '0 : hi[XOUT_W-1:0];
        s.empty = off;
        s.colour = colour_reg;
        s.last = fin;
        return 1;
    endfunction

    function automatic tri_t noise_tri();
        tri_t t;
        t.ax = COORD_W'($urandom); t.ay = COORD_W'($urandom);
        t.bx = COORD_W'($urandom); t.by = COORD_W'($urandom);
        t.cx = COORD_W'($urandom); t.cy = COORD_W'($urandom);
        return t;
    endfunction

    // small triangle placed around the visible area, with y ties now and then
    function automatic tri_t random_triangle();
        tri_t t;
        int ox, oy, spread;
        spread = ($urandom_range(0, 7) == 0) ? 60 : 12;
        ox = int'($urandom_range(0, 32'(clip_w + 40))) - 20;
        oy = int'($urandom_range(0, 32'(clip_h + 40))) - 20;
        if (ox > 4095 - spread)
            ox = 4095 - spread;
        if (oy > 4095 - spread)
            oy = 4095 - spread;
        t.ax = COORD_W'(ox + int'($urandom_range(0, 2*spread)) - spread);
        t.ay = COORD_W'(oy + int'($urandom_range(0, 2*spread)) - spread);
        t.bx = COORD_W'(ox + int'($urandom_range(0, 2*spread)) - spread);
        t.by = COORD_W'(oy + int'($urandom_range(0, 2*spread)) - spread);
        t.cx = COORD_W'(ox + int'($urandom_range(0, 2*spread)) - spread);
        t.cy = COORD_W'(oy + int'($urandom_range(0, 2*spread)) - spread);
        case ($urandom_range(0, 7))
            0: t.by = t.ay;
            1: t.cy = t.by;
            2: t.cy = t.ay;
            3:
            begin
                t.by = t.ay;
                t.cy = t.ay;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_item(input logic cmd, input tri_t t);
        int gap;
        span_exp_t s;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_W-6*COORD_W){1'b0}}, t.cy, t.cx, t.by, t.bx, t.ay, t.ax};
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_START || phase != PH_IDLE)
            busy_items++;
        if (cmd == CMD_START)
            load_triangle(t);
        else if (raster_step(s))
            expected_spans = {expected_spans, s};
        burst_left--;
        @(negedge clk);
    endtask

    task automatic run_triangle(input tri_t t, input int max_steps);
        int n;
        send_item(CMD_START, t);
        n = 0;
        while (phase != PH_IDLE && n < max_steps)
        begin
            send_item(CMD_STEP, noise_tri());
            n++;
        end
    endtask

    // drain all spans and let any division in flight finish
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input int w, input int h, input logic [COLOUR_W-1:0] colour);
        cfg_idx_t         idx[3];
        logic [23:0]      vals[3];
        idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_FILL_COLOUR};
        vals = '{24'(w), 24'(h), colour};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        clip_w = longint'(w);
        clip_h = longint'(h);
        colour_reg = colour;
    endtask

    task automatic test_idle_step();
        send_item(CMD_STEP, noise_tri());
    endtask

    task automatic test_directed_shapes();
        // extreme corners, dropped after two spans by the next start
        run_triangle(tri_t'{-4096, -4096, 4095, 4095, -4096, 4095}, 2);
        // all three on one row
        run_triangle(tri_t'{5, 7, 9, 7, 1, 7}, 1000);
        send_item(CMD_STEP, noise_tri());
        // flat bottom
        run_triangle(tri_t'{10, 5, 2, 9, 20, 9}, 1000);
        // flat top, its top row skipped
        run_triangle(tri_t'{3, 2, 15, 2, 8, 6}, 1000);
        // unsorted, partly above and right of the image
        run_triangle(tri_t'{700, 1, 100, 3, -20, -1}, 1000);
    endtask

    task automatic test_clip_extremes();
        settle();
        set_config(1, 1, 24'hFFFFFF);
        repeat (6) run_triangle(random_triangle(), 1000);
        settle();
        set_config(4096, 4096, 24'h000000);
        run_triangle(tri_t'{4090, 4093, 4095, 4095, 4080, 4095}, 1000);
        run_triangle(tri_t'{-30, -3, 4095, 2, 10, 4}, 1000);
        repeat (6) run_triangle(random_triangle(), 1000);
    endtask

    function automatic int random_dim();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 16);
            1: return $urandom_range(17, 700);
            2: return 4096;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    task automatic test_random_fill();
        int target;
        busy_items = 0;
        target = 0;
        for (int p = 0; p < 6; p++)
        begin
            settle();
            set_config(random_dim(), random_dim(), COLOUR_W'($urandom));
            gap_max = (p % 3) * 4;
            target += 250;
            while (busy_items < target)
            begin
                if ($urandom_range(0, 15) == 0)
                    run_triangle(noise_tri(), $urandom_range(0, 6));
                else if ($urandom_range(0, 7) == 0)
                    run_triangle(random_triangle(), $urandom_range(0, 30));
                else
                    run_triangle(random_triangle(), 1000);
                if ($urandom_range(0, 5) == 0)
                    send_item(CMD_STEP, noise_tri());
            end
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_left % 9 == 0);
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: span %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        span_exp_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.row = m_tdata[12:0];
            got.start_x = m_tdata[24:13];
            got.end_x = m_tdata[36:25];
            got.colour = m_tdata[60:37];
            got.empty = m_tuser[0];
            got.last = m_tlast;
            if (expected_spans.size() == 0)
            begin
                $display("%0t: unexpected span transfer, expected none, got row %0d",
                         $time, $signed(got.row));
                errors++;
            end
            else
            begin
                want = expected_spans.pop_front();
                check_field("row", 32'(want.row), 32'(got.row));
                check_field("start_x", 32'(want.start_x), 32'(got.start_x));
                check_field("end_x", 32'(want.end_x), 32'(got.end_x));
                check_field("empty", 32'(want.empty), 32'(got.empty));
                check_field("colour", 32'(want.colour), 32'(got.colour));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_step();
        test_directed_shapes();
        test_clip_extremes();
        test_random_fill();
        settle();
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tsf_pkg.sv
rtl/tsf_div.sv
rtl/tsf_seq.sv
rtl/tsf_dp.sv
rtl/triangle_scanline_fill.sv
verif/tb_top.sv
